### rtl/core/mca_pkg.sv
package mca_pkg;

  // Fixed field widths of the channels and registers
  localparam int COST_W      = 32;
  localparam int TOTAL_W     = 38;
  localparam int DIM_W       = 7;
  localparam int CFG_INDEX_W = 2;

  // Register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_ROW_COUNT    = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_COLUMN_COUNT = 2'd1;

  // Sequencer states, one-hot
  typedef enum logic [11:0] {
    ST_LOAD  = 12'b0000_0000_0001,
    ST_TREE  = 12'b0000_0000_0010,
    ST_PICK  = 12'b0000_0000_0100,
    ST_RPOT  = 12'b0000_0000_1000,
    ST_SCAN  = 12'b0000_0001_0000,
    ST_AUG   = 12'b0000_0010_0000,
    ST_AUG1  = 12'b0000_0100_0000,
    ST_AUG2  = 12'b0000_1000_0000,
    ST_SLACK = 12'b0001_0000_0000,
    ST_UPD   = 12'b0010_0000_0000,
    ST_SUM   = 12'b0100_0000_0000,
    ST_POST  = 12'b1000_0000_0000
  } state_t;

endpackage

### rtl/core/mca_in_if.sv
interface mca_in_if;
  logic                       valid;
  logic                       ready;
  logic [mca_pkg::COST_W-1:0] cost;
  logic                       absent;

  modport source (output valid, output cost, output absent, input ready);
  modport sink   (input valid, input cost, input absent, output ready);
endinterface

### rtl/core/mca_out_if.sv
interface mca_out_if;
  logic                        valid;
  logic                        ready;
  logic [mca_pkg::TOTAL_W-1:0] total_cost;
  logic                        infeasible;

  modport source (output valid, output total_cost, output infeasible, input ready);
  modport sink   (input valid, input total_cost, input infeasible, output ready);
endinterface

### rtl/core/min_cost_assignment.sv
// Minimum-cost assignment of rows to distinct columns (Hungarian method).
// Set row_count and column_count on the write port while idle; a write to
// either count restarts loading. Then send the cost matrix on the entries
// channel in row-major order, one request per entry per cycle; absent marks
// a forbidden edge. After the last entry the solver runs from the stored
// matrix and one request on the result channel carries total_cost, or
// infeasible with a zero total. Per tree, solving scans the columns of every
// row it scans, walks the augmenting path back to the root, and for a
// potential shift sweeps all entries for the least slack, then all columns;
// it is bound by the single read port of the cost store. A job ends with a
// sum of the chosen entries over all rows.
// Reset is synchronous: the block returns to loading, with 1 x 1 dimensions
// and no result pending. The cost store is not cleared; a job reads only
// entries it loaded. A finished result waits in the output register while
// the next matrix loads; if a second result is ready before the receiver
// takes the first, the solver holds it until the output register frees.
module min_cost_assignment #(
  parameter int MAX_ROWS    = 64,
  parameter int MAX_COLUMNS = 64,
  parameter int COST_BITS   = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            write_enable,
  input  logic [mca_pkg::CFG_INDEX_W-1:0] write_index,
  input  logic [mca_pkg::DIM_W-1:0]       write_data,
  mca_in_if.sink                          entries,
  mca_out_if.source                       result
);

  localparam int ROW_W   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int COL_W   = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int RCNT_W  = $clog2(MAX_ROWS + 1);
  localparam int CCNT_W  = $clog2(MAX_COLUMNS + 1);
  localparam int DEPTH   = MAX_ROWS * MAX_COLUMNS;
  localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int ENTRY_W = COST_BITS + 1;
  localparam int POT_W   = COST_BITS + 16;
  localparam int SUM_W   = ((COST_BITS > mca_pkg::TOTAL_W) ? COST_BITS : mca_pkg::TOTAL_W) + 1;

  function automatic logic [ADDR_W-1:0] cost_addr(logic [ROW_W-1:0] r, logic [COL_W-1:0] c);
    return ADDR_W'(32'(r) * MAX_COLUMNS + 32'(c));
  endfunction

  function automatic logic [RCNT_W-1:0] clamp_rows(logic [mca_pkg::DIM_W-1:0] v);
    if (v == '0) return RCNT_W'(1);
    else if (32'(v) > MAX_ROWS) return RCNT_W'(MAX_ROWS);
    else return RCNT_W'(v);
  endfunction

  function automatic logic [CCNT_W-1:0] clamp_cols(logic [mca_pkg::DIM_W-1:0] v);
    if (v == '0) return CCNT_W'(1);
    else if (32'(v) > MAX_COLUMNS) return CCNT_W'(MAX_COLUMNS);
    else return CCNT_W'(v);
  endfunction

  mca_pkg::state_t state;

  // Dimensions and load counters
  logic [RCNT_W-1:0] h;
  logic [CCNT_W-1:0] n;
  logic [ROW_W-1:0]  lr;
  logic [COL_W-1:0]  lc;

  // Per-entry flags
  logic [MAX_ROWS-1:0]    in_tree, scanned, rpv, row_matched;
  logic [MAX_COLUMNS-1:0] vis, cpv, col_matched;

  // Tree search
  logic [RCNT_W-1:0]      i;
  logic [ROW_W-1:0]       r_cur;
  logic signed [POT_W-1:0] u_cur;
  logic [CCNT_W-1:0]      j;
  logic [COL_W-1:0]       jd;
  logic                   sv;
  logic [COL_W-1:0]       aug_col;
  logic [ROW_W-1:0]       aug_row;

  // Slack search
  logic [RCNT_W-1:0]       sr;
  logic [CCNT_W-1:0]       sj;
  logic                    s1v, slv, found;
  logic [ROW_W-1:0]        s1r;
  logic [COL_W-1:0]        s1j;
  logic signed [POT_W-1:0] sl, d;

  // Potential update and final sum
  logic [CCNT_W-1:0] k;
  logic              uv, av, bv;
  logic [COL_W-1:0]  kd;
  logic [ROW_W-1:0]  ka;
  logic [SUM_W-1:0]  sum, sum_add;

  // Result
  logic [mca_pkg::TOTAL_W-1:0] res_total, out_total;
  logic                        res_inf, out_inf, out_valid;

  // Memories
  logic [ENTRY_W-1:0] cost_mem [DEPTH];
  logic [POT_W-1:0]   rpot_mem [MAX_ROWS];
  logic [POT_W-1:0]   cpot_mem [MAX_COLUMNS];
  logic [ROW_W-1:0]   parent_mem [MAX_COLUMNS];
  logic [COL_W-1:0]   rpart_mem [MAX_ROWS];
  logic [ROW_W-1:0]   cpart_mem [MAX_COLUMNS];

  logic [ENTRY_W-1:0] cost_q;
  logic [POT_W-1:0]   rpot_q, cpot_q;
  logic               rpot_qv, cpot_qv, rpart_qv, cpart_qv;
  logic [ROW_W-1:0]   parent_q, cpart_q;
  logic [COL_W-1:0]   rpart_q;

  logic [ADDR_W-1:0] cost_raddr;
  logic [ROW_W-1:0]  rpot_raddr, rpart_raddr;
  logic [COL_W-1:0]  cpot_raddr, parent_raddr, cpart_raddr;

  logic                    rpot_we, cpot_we, parent_we, accept;
  logic [ROW_W-1:0]        upd_row;
  logic signed [POT_W-1:0] rpot_val, cpot_val, e_ext, slack_val;
  logic                    scan_tight, slack_ok, have_pick;
  logic [ROW_W-1:0]        pick;
  logic [MAX_ROWS-1:0]     cand;

  assign accept = entries.valid && entries.ready;
  assign entries.ready = (state == mca_pkg::ST_LOAD);
  assign result.valid = out_valid;
  assign result.total_cost = out_total;
  assign result.infeasible = out_inf;

  // Decode stored values
  assign rpot_val = rpot_qv ? $signed(rpot_q) : '0;
  assign cpot_val = cpot_qv ? $signed(cpot_q) : '0;
  assign e_ext = $signed({{(POT_W - COST_BITS){1'b0}}, cost_q[COST_BITS-1:0]});
  assign scan_tight = sv && !vis[jd] && !cost_q[COST_BITS] && (u_cur + cpot_val == e_ext);
  assign slack_val = e_ext - rpot_val - cpot_val;
  assign slack_ok = s1v && in_tree[s1r] && !vis[s1j] && !cost_q[COST_BITS];
  assign upd_row = ROW_W'(kd);
  assign rpot_we = (state == mca_pkg::ST_UPD) && uv && (32'(kd) < 32'(h)) && in_tree[upd_row];
  assign cpot_we = (state == mca_pkg::ST_UPD) && uv && vis[kd];
  assign parent_we = (state == mca_pkg::ST_SCAN) && scan_tight;
  assign sum_add = sum + SUM_W'(cost_q[COST_BITS-1:0]);

  // Pick the lowest tree row not yet scanned
  assign cand = in_tree & ~scanned;
  assign have_pick = |cand;
  always_comb begin
    pick = '0;
    for (int x = MAX_ROWS - 1; x >= 0; x--) begin
      if (cand[x]) pick = ROW_W'(x);
    end
  end

  // Steer memory read addresses
  always_comb begin
    cost_raddr   = '0;
    rpot_raddr   = '0;
    cpot_raddr   = '0;
    parent_raddr = aug_col;
    rpart_raddr  = '0;
    cpart_raddr  = '0;
    unique case (state)
      mca_pkg::ST_PICK: rpot_raddr = pick;
      mca_pkg::ST_SCAN: begin
        cost_raddr  = cost_addr(r_cur, j[COL_W-1:0]);
        cpot_raddr  = j[COL_W-1:0];
        cpart_raddr = j[COL_W-1:0];
      end
      mca_pkg::ST_AUG1: rpart_raddr = parent_q;
      mca_pkg::ST_SLACK: begin
        cost_raddr = cost_addr(sr[ROW_W-1:0], sj[COL_W-1:0]);
        rpot_raddr = sr[ROW_W-1:0];
        cpot_raddr = sj[COL_W-1:0];
      end
      mca_pkg::ST_UPD: begin
        rpot_raddr = ROW_W'(k);
        cpot_raddr = COL_W'(k);
      end
      mca_pkg::ST_SUM: begin
        rpart_raddr = ROW_W'(k);
        cost_raddr  = cost_addr(ka, rpart_q);
      end
      default: ;
    endcase
  end

  // Memories: one write, one registered read each
  always_ff @(posedge clk) begin
    if (accept) begin
      cost_mem[cost_addr(lr, lc)] <= entries.absent ? {1'b1, {COST_BITS{1'b0}}}
                                                    : {1'b0, COST_BITS'(entries.cost)};
    end
    if (rpot_we) rpot_mem[upd_row] <= rpot_val + d;
    if (cpot_we) cpot_mem[kd] <= cpot_val - d;
    if (parent_we) parent_mem[jd] <= r_cur;
    if (state == mca_pkg::ST_AUG2) begin
      rpart_mem[aug_row] <= aug_col;
      cpart_mem[aug_col] <= aug_row;
    end
    cost_q   <= cost_mem[cost_raddr];
    rpot_q   <= rpot_mem[rpot_raddr];
    rpot_qv  <= rpv[rpot_raddr];
    cpot_q   <= cpot_mem[cpot_raddr];
    cpot_qv  <= cpv[cpot_raddr];
    parent_q <= parent_mem[parent_raddr];
    rpart_q  <= rpart_mem[rpart_raddr];
    rpart_qv <= row_matched[rpart_raddr];
    cpart_q  <= cpart_mem[cpart_raddr];
    cpart_qv <= col_matched[cpart_raddr];
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= mca_pkg::ST_LOAD;
      h         <= RCNT_W'(1);
      n         <= CCNT_W'(1);
      lr        <= '0;
      lc        <= '0;
      out_valid <= 1'b0;
      sv        <= 1'b0;
      s1v       <= 1'b0;
      slv       <= 1'b0;
      uv        <= 1'b0;
      av        <= 1'b0;
      bv        <= 1'b0;
      found     <= 1'b0;
      i         <= '0;
      in_tree   <= '0;
      scanned   <= '0;
      vis       <= '0;
      rpv       <= '0;
      cpv       <= '0;
      row_matched <= '0;
      col_matched <= '0;
    end else begin
      // Drop a result the receiver took
      if (result.valid && result.ready && (state != mca_pkg::ST_POST)) out_valid <= 1'b0;

      // Take register writes and restart loading
      if (write_enable) begin
        unique case (write_index)
          mca_pkg::REG_ROW_COUNT: begin
            h  <= clamp_rows(write_data);
            lr <= '0;
            lc <= '0;
          end
          mca_pkg::REG_COLUMN_COUNT: begin
            n  <= clamp_cols(write_data);
            lr <= '0;
            lc <= '0;
          end
          default: ;
        endcase
      end

      if (rpot_we) rpv[upd_row] <= 1'b1;
      if (cpot_we) cpv[kd] <= 1'b1;

      unique case (state)
        mca_pkg::ST_LOAD: begin
          if (accept) begin
            if (CCNT_W'(lc) + CCNT_W'(1) == n) begin
              lc <= '0;
              if (RCNT_W'(lr) + RCNT_W'(1) == h) begin
                lr <= '0;
                if (32'(h) > 32'(n)) begin
                  res_total <= '0;
                  res_inf   <= 1'b1;
                  state     <= mca_pkg::ST_POST;
                end else begin
                  rpv         <= '0;
                  cpv         <= '0;
                  row_matched <= '0;
                  col_matched <= '0;
                  i           <= '0;
                  state       <= mca_pkg::ST_TREE;
                end
              end else begin
                lr <= lr + ROW_W'(1);
              end
            end else begin
              lc <= lc + COL_W'(1);
            end
          end
        end
        mca_pkg::ST_TREE: begin
          vis     <= '0;
          scanned <= '0;
          in_tree <= MAX_ROWS'(1) << i;
          state   <= mca_pkg::ST_PICK;
        end
        mca_pkg::ST_PICK: begin
          if (have_pick) begin
            r_cur          <= pick;
            scanned[pick]  <= 1'b1;
            state          <= mca_pkg::ST_RPOT;
          end else begin
            sr    <= '0;
            sj    <= '0;
            found <= 1'b0;
            s1v   <= 1'b0;
            slv   <= 1'b0;
            state <= mca_pkg::ST_SLACK;
          end
        end
        mca_pkg::ST_RPOT: begin
          u_cur <= rpot_val;
          j     <= '0;
          sv    <= 1'b0;
          state <= mca_pkg::ST_SCAN;
        end
        mca_pkg::ST_SCAN: begin
          // Issue the next column, then check the one read last cycle
          sv <= (j < n);
          if (j < n) begin
            jd <= j[COL_W-1:0];
            j  <= j + CCNT_W'(1);
          end
          if (scan_tight) begin
            vis[jd] <= 1'b1;
            if (cpart_qv) begin
              in_tree[cpart_q] <= 1'b1;
            end else begin
              aug_col <= jd;
              state   <= mca_pkg::ST_AUG;
            end
          end else if ((j == n) && !sv) begin
            state <= mca_pkg::ST_PICK;
          end
        end
        mca_pkg::ST_AUG: state <= mca_pkg::ST_AUG1;
        mca_pkg::ST_AUG1: begin
          aug_row <= parent_q;
          state   <= mca_pkg::ST_AUG2;
        end
        mca_pkg::ST_AUG2: begin
          // Flip one edge of the augmenting path
          col_matched[aug_col] <= 1'b1;
          row_matched[aug_row] <= 1'b1;
          if (rpart_qv) begin
            aug_col <= rpart_q;
            state   <= mca_pkg::ST_AUG;
          end else begin
            i <= i + RCNT_W'(1);
            if (i + RCNT_W'(1) == h) begin
              k     <= '0;
              av    <= 1'b0;
              bv    <= 1'b0;
              sum   <= '0;
              state <= mca_pkg::ST_SUM;
            end else begin
              state <= mca_pkg::ST_TREE;
            end
          end
        end
        mca_pkg::ST_SLACK: begin
          // Sweep every row and column, keep the least slack of a tree row to an unvisited column
          if (sr < h) begin
            s1v <= 1'b1;
            s1r <= sr[ROW_W-1:0];
            s1j <= sj[COL_W-1:0];
            if (sj + CCNT_W'(1) == n) begin
              sj <= '0;
              sr <= sr + RCNT_W'(1);
            end else begin
              sj <= sj + CCNT_W'(1);
            end
          end else begin
            s1v <= 1'b0;
          end
          slv <= slack_ok;
          sl  <= slack_val;
          if (slv && (!found || (sl < d))) begin
            d     <= sl;
            found <= 1'b1;
          end
          if ((sr == h) && !s1v && !slv) begin
            if (found) begin
              k     <= '0;
              uv    <= 1'b0;
              state <= mca_pkg::ST_UPD;
            end else begin
              res_total <= '0;
              res_inf   <= 1'b1;
              state     <= mca_pkg::ST_POST;
            end
          end
        end
        mca_pkg::ST_UPD: begin
          // Shift potentials of tree rows and visited columns
          uv <= (k < n);
          if (k < n) begin
            kd <= k[COL_W-1:0];
            k  <= k + CCNT_W'(1);
          end
          if ((k == n) && !uv) state <= mca_pkg::ST_TREE;
        end
        mca_pkg::ST_SUM: begin
          // Add up the chosen entries, saturating
          av <= (32'(k) < 32'(h));
          if (32'(k) < 32'(h)) begin
            ka <= ROW_W'(k);
            k  <= k + CCNT_W'(1);
          end
          bv <= av;
          if (bv) begin
            sum <= (sum_add > SUM_W'({mca_pkg::TOTAL_W{1'b1}}))
                   ? SUM_W'({mca_pkg::TOTAL_W{1'b1}}) : sum_add;
          end
          if ((32'(k) == 32'(h)) && !av && !bv) begin
            res_total <= sum[mca_pkg::TOTAL_W-1:0];
            res_inf   <= 1'b0;
            state     <= mca_pkg::ST_POST;
          end
        end
        mca_pkg::ST_POST: begin
          // Hold until the output register frees
          if (!out_valid || result.ready) begin
            out_total <= res_total;
            out_inf   <= res_inf;
            out_valid <= 1'b1;
            state     <= mca_pkg::ST_LOAD;
          end
        end
        default: state <= mca_pkg::ST_LOAD;
      endcase
    end
  end

endmodule
